@@ rtl/egcd_pkg.sv @@
`timescale 1ns / 1ps
package egcd_pkg;
   localparam int WordBits = 64;
   localparam int CntBits  = 7;
   localparam logic [WordBits-1:0] SignedMax = {1'b0, {(WordBits-1){1'b1}}};

   typedef logic [WordBits-1:0] word_type;

   // Control from the sequencer to the datapath unit.
   typedef struct packed {
      logic start;
   } div_ctl_type;
endpackage

@@ rtl/extended_gcd_bezout_core.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Signals
// request   in         req_valid, req_ready, req_a, req_b
// response  out        rsp_valid, rsp_ready, rsp_gcd, rsp_coeff_x, rsp_coeff_y,
//                      rsp_coeffs_dropped
// One request runs one Euclid step after another: a test state, a divide,
// then two checked coefficient updates (s, then t) on the shared unit.
// Once coefficients are dropped, a step is the test and divide only.
// Up to 92 steps per request, plus entry and exit.
// Reset is synchronous and active high; it clears the sequencer.
// req_ready is high only when idle and the response register is empty;
// a stalled response holds until taken.
module extended_gcd_bezout_core
   import egcd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  word_type req_a,
   input  word_type req_b,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output word_type rsp_gcd,
   output word_type rsp_coeff_x,
   output word_type rsp_coeff_y,
   output logic     rsp_coeffs_dropped
);
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StDiv  = 3'd1;
   localparam logic [2:0] StUpdS = 3'd2;
   localparam logic [2:0] StUpdT = 3'd3;
   localparam logic [2:0] StDone = 3'd4;
   localparam logic [2:0] StTest = 3'd5;

   logic [2:0] state_ff, state_in;
   word_type   old_r_ff, old_r_in, r_ff, r_in;
   word_type   old_s_ff, old_s_in, s_ff, s_in;
   word_type   old_t_ff, old_t_in, t_ff, t_in;
   word_type   q_ff, q_in, nr_ff, nr_in, ns_ff, ns_in;
   logic       drop_ff, drop_in;
   logic       rsp_valid_ff, rsp_valid_in;
   word_type   gcd_ff, gcd_in, cx_ff, cx_in, cy_ff, cy_in;
   logic       dr_ff, dr_in;
   div_ctl_type div_ctl;
   logic        cu_start;
   logic        cu_launched_ff, cu_launched_in;
   word_type    cu_old, cu_cur;
   logic        div_done, cu_done, cu_ok;
   word_type    div_q, div_rem, cu_res;

   egcd_divider u_div (
      .clock(clock), .reset(reset), .start(div_ctl.start),
      .dividend(old_r_ff), .divisor(r_ff),
      .done(div_done), .quotient(div_q), .remainder(div_rem)
   );

   egcd_coef_update u_cu (
      .clock(clock), .reset(reset), .start(cu_start), .q(q_ff),
      .old_c(cu_old), .cur_c(cu_cur),
      .done(cu_done), .ok(cu_ok), .result(cu_res)
   );

   assign req_ready = (state_ff == StIdle) && !rsp_valid_ff;
   assign cu_old    = (state_ff == StUpdT) ? old_t_ff : old_s_ff;
   assign cu_cur    = (state_ff == StUpdT) ? t_ff : s_ff;

   always_comb begin
      state_in     = state_ff;
      old_r_in = old_r_ff; r_in = r_ff;
      old_s_in = old_s_ff; s_in = s_ff;
      old_t_in = old_t_ff; t_in = t_ff;
      q_in = q_ff; nr_in = nr_ff; ns_in = ns_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff;
      gcd_in = gcd_ff; cx_in = cx_ff; cy_in = cy_ff; dr_in = dr_ff;
      div_ctl.start = 1'b0;
      cu_start      = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         StIdle: begin
            if (req_valid && req_ready) begin
               old_r_in = req_a; r_in = req_b;
               old_s_in = word_type'(1); s_in = '0;
               old_t_in = '0; t_in = word_type'(1);
               drop_in  = 1'b0;
               state_in = StTest;
            end
         end
         StTest: begin
            // Loop while the current remainder is nonzero.
            if (r_ff == '0) state_in = StDone;
            else begin
               div_ctl.start = 1'b1;
               state_in = StDiv;
            end
         end
         StDiv: begin
            if (div_done) begin
               q_in  = div_q;
               nr_in = div_rem;
               if (drop_ff) begin
                  old_r_in = r_ff; r_in = div_rem; state_in = StTest;
               end else if (div_q > SignedMax) begin
                  drop_in = 1'b1;
                  old_r_in = r_ff; r_in = div_rem; state_in = StTest;
               end else begin
                  state_in = StUpdS;
               end
            end
         end
         StUpdS: begin
            cu_start = !cu_launched_ff;
            if (cu_done) begin
               if (!cu_ok) begin
                  drop_in = 1'b1;
                  old_r_in = r_ff; r_in = nr_ff; state_in = StTest;
               end else begin
                  ns_in = cu_res; state_in = StUpdT;
               end
            end
         end
         StUpdT: begin
            cu_start = !cu_launched_ff;
            if (cu_done) begin
               if (cu_ok) begin
                  old_s_in = s_ff; s_in = ns_ff;
                  old_t_in = t_ff; t_in = cu_res;
               end else drop_in = 1'b1;
               old_r_in = r_ff; r_in = nr_ff; state_in = StTest;
            end
         end
         StDone: begin
            gcd_in = old_r_ff;
            cx_in  = drop_ff ? '0 : old_s_ff;
            cy_in  = drop_ff ? '0 : old_t_ff;
            dr_in  = drop_ff;
            if (old_r_ff == '0) begin
               cx_in = '0; cy_in = '0; dr_in = 1'b0;
            end
            rsp_valid_in = 1'b1;
            state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   // Start the update unit once on entry to each update state.
   always_comb begin
      cu_launched_in = cu_launched_ff;
      if (cu_start) cu_launched_in = 1'b1;
      if (cu_done) cu_launched_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= StIdle;
         rsp_valid_ff   <= 1'b0;
         cu_launched_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         cu_launched_ff <= cu_launched_in;
      end
      old_r_ff <= old_r_in; r_ff <= r_in;
      old_s_ff <= old_s_in; s_ff <= s_in;
      old_t_ff <= old_t_in; t_ff <= t_in;
      q_ff <= q_in; nr_ff <= nr_in; ns_ff <= ns_in;
      drop_ff <= drop_in;
      gcd_ff <= gcd_in; cx_ff <= cx_in; cy_ff <= cy_in; dr_ff <= dr_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_gcd            = gcd_ff;
   assign rsp_coeff_x        = cx_ff;
   assign rsp_coeff_y        = cy_ff;
   assign rsp_coeffs_dropped = dr_ff;
endmodule

@@ rtl/egcd_divider.sv @@
`timescale 1ns / 1ps
module egcd_divider
   import egcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  word_type    dividend,
   input  word_type    divisor,
   output logic        done,
   output word_type    quotient,
   output word_type    remainder
);
   // Restoring division, one quotient bit per cycle.
   logic [CntBits-1:0] count_ff, count_in;
   logic               busy_ff, busy_in;
   word_type           quot_ff, quot_in;
   word_type           rem_ff, rem_in;
   word_type           div_ff, div_in;
   logic               done_ff, done_in;
   logic [WordBits:0]  trial;
   logic [WordBits:0]  shifted;

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      done_in  = 1'b0;
      shifted  = {rem_ff, quot_ff[WordBits-1]};
      trial    = shifted - {1'b0, div_ff};
      if (start) begin
         busy_in  = 1'b1;
         count_in = CntBits'(WordBits);
         quot_in  = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         if (!trial[WordBits]) begin
            rem_in  = trial[WordBits-1:0];
            quot_in = {quot_ff[WordBits-2:0], 1'b1};
         end else begin
            rem_in  = shifted[WordBits-1:0];
            quot_in = {quot_ff[WordBits-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;
endmodule

@@ rtl/egcd_coef_update.sv @@
`timescale 1ns / 1ps
module egcd_coef_update
   import egcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  word_type    q,
   input  word_type    old_c,
   input  word_type    cur_c,
   output logic        done,
   output logic        ok,
   output word_type    result
);
   // next = old - q*cur, checked. Shift-add multiply, one bit a cycle.
   // The product magnitude is tracked with an overflow sticky bit.
   localparam int AccBits = WordBits + 1;
   logic [CntBits-1:0] count_ff, count_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               ovf_ff, ovf_in;
   logic [AccBits-1:0] acc_ff, acc_in;
   logic [AccBits-1:0] mcand_ff, mcand_in;
   word_type           q_ff, q_in;
   logic               neg_ff, neg_in;
   word_type           old_ff, old_in;
   logic               ok_ff, ok_in;
   word_type           res_ff, res_in;
   logic [AccBits:0]   sum;
   logic [AccBits-1:0] lim;
   word_type           prod;
   logic [WordBits:0]  diff;

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      ovf_in   = ovf_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      q_in     = q_ff;
      neg_in   = neg_ff;
      old_in   = old_ff;
      ok_in    = ok_ff;
      res_in   = res_ff;
      sum      = {1'b0, acc_ff} + {1'b0, mcand_ff};
      lim      = {1'b0, SignedMax} + AccBits'(neg_ff);
      prod     = neg_ff ? (word_type'(0) - acc_ff[WordBits-1:0]) : acc_ff[WordBits-1:0];
      diff     = {old_ff[WordBits-1], old_ff} - {prod[WordBits-1], prod};
      if (start) begin
         busy_in  = 1'b1;
         count_in = CntBits'(WordBits);
         ovf_in   = 1'b0;
         acc_in   = '0;
         neg_in   = cur_c[WordBits-1];
         mcand_in = {1'b0, cur_c[WordBits-1] ? (word_type'(0) - cur_c) : cur_c};
         q_in     = q;
         old_in   = old_c;
      end else if (busy_ff && count_ff != '0) begin
         // Process q from its low bit; the multiplicand doubles each step until it exceeds the limit.
         if (q_ff[0]) begin
            if (sum > {1'b0, lim} || mcand_ff > lim) ovf_in = 1'b1;
            else acc_in = sum[AccBits-1:0];
         end
         if (mcand_ff > lim) mcand_in = mcand_ff;
         else mcand_in = {mcand_ff[AccBits-2:0], 1'b0};
         if (mcand_ff > lim && q_ff[WordBits-1:1] != '0) ovf_in = 1'b1;
         q_in     = {1'b0, q_ff[WordBits-1:1]};
         count_in = count_ff - 1'b1;
      end else if (busy_ff) begin
         busy_in = 1'b0;
         done_in = 1'b1;
         ok_in   = !ovf_ff && (diff[WordBits] == diff[WordBits-1]);
         res_in  = diff[WordBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      ovf_ff   <= ovf_in;
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      q_ff     <= q_in;
      neg_ff   <= neg_in;
      old_ff   <= old_in;
      ok_ff    <= ok_in;
      res_ff   <= res_in;
   end

   assign done   = done_ff;
   assign ok     = ok_ff;
   assign result = res_ff;
endmodule
